// File: rtl/core/upc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character constants and helper functions of the URL percent
// codec.
// ----------------------------------------------------------------------------
package upc_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Held-byte state of the decoder.
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PCT   = 2'd1;
   localparam logic [1:0] PEND_DIGIT = 2'd2;

   localparam int unsigned NUM_SLOTS = 3;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][7:0] res_byte;   // slot 0 goes out first
      logic [1:0]                res_count;
      logic [1:0]                next_count;
      logic                      digit_we;
   } step_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         v = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end
      hex_value = v[3:0];
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < 4'd10) begin
         hex_digit = 8'h30 + {4'h0, v};
      end else begin
         hex_digit = 8'h37 + {4'h0, v};
      end
   endfunction

   // Control bytes, DEL and above, and the reserved, delimiter and unwise sets.
   function automatic logic must_escape(input logic [7:0] c);
      must_escape = (c inside {[8'h00:8'h1F], [8'h7F:8'hFF],
                               8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D,
                               8'h2B, 8'h24, 8'h2C, 8'h3C, 8'h3E, 8'h23, 8'h25,
                               8'h22, 8'h7B, 8'h7D, 8'h7C, 8'h5C, 8'h5E, 8'h5B,
                               8'h5D, 8'h60});
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/url_percent_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_codec
// Byte-stream URL percent encoder and decoder with an APB-style mode register.
// ----------------------------------------------------------------------------
// Each accepted item is converted in the cycle it is taken and its result
// bytes are loaded into a three-byte result register that drains one byte per
// cycle while rsp_ready is high. An item that yields one byte (or none, while
// the decoder holds a '%' or a hex digit) can follow in the next cycle; an
// item that yields more bytes holds off the next item until they have drained.
// The next item is taken in the same cycle the last waiting byte leaves.
// Writing the mode register drops any held bytes.
module url_percent_codec (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   // Result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_end,
   output logic             rsp_string_end,
   // Register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic                                 decode_mode_ff, decode_mode_in;
   logic [1:0]                           pend_count_ff, pend_count_in;
   logic [7:0]                           pend_digit_ff, pend_digit_in;
   logic [upc_pkg::NUM_SLOTS-1:0][7:0]   buf_byte_ff, buf_byte_in;
   logic [1:0]                           buf_count_ff, buf_count_in;
   logic                                 buf_last_ff, buf_last_in;

   upc_pkg::step_type step;
   logic              req_take;
   logic              rsp_take;
   logic              csr_write;

   upc_step u_step (
      .decode_mode (decode_mode_ff),
      .pend_count  (pend_count_ff),
      .pend_digit  (pend_digit_ff),
      .in_byte     (req_in_byte),
      .in_last     (req_in_last),
      .step        (step)
   );

   assign rsp_valid      = (buf_count_ff != 2'd0);
   assign rsp_out_byte   = buf_byte_ff[0];
   assign rsp_run_end    = (buf_count_ff == 2'd1);
   assign rsp_string_end = rsp_run_end && buf_last_ff;
   assign rsp_take       = rsp_valid && rsp_ready;

   assign req_ready = (buf_count_ff == 2'd0) || (rsp_take && buf_count_ff == 2'd1);
   assign req_take  = req_valid && req_ready;

   assign pready    = 1'b1;
   assign prdata    = {31'd0, decode_mode_ff};
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      decode_mode_in = decode_mode_ff;
      pend_count_in  = pend_count_ff;
      pend_digit_in  = pend_digit_ff;
      buf_byte_in    = buf_byte_ff;
      buf_count_in   = buf_count_ff;
      buf_last_in    = buf_last_ff;

      if (rsp_take) begin
         buf_byte_in  = {8'h00, buf_byte_ff[upc_pkg::NUM_SLOTS-1:1]};
         buf_count_in = buf_count_ff - 2'd1;
      end

      if (req_take) begin
         pend_count_in = step.next_count;
         if (step.digit_we) begin
            pend_digit_in = req_in_byte;
         end
         if (step.res_count != 2'd0) begin
            buf_byte_in  = step.res_byte;
            buf_count_in = step.res_count;
            buf_last_in  = req_in_last;
         end
      end

      // Register index 0 is the only register; higher words are ignored.
      if (csr_write && paddr[2] == 1'b0) begin
         decode_mode_in = pwdata[0];
         pend_count_in  = upc_pkg::PEND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         pend_count_ff  <= upc_pkg::PEND_NONE;
         buf_count_ff   <= 2'd0;
      end else begin
         decode_mode_ff <= decode_mode_in;
         pend_count_ff  <= pend_count_in;
         buf_count_ff   <= buf_count_in;
      end
      pend_digit_ff <= pend_digit_in;
      buf_byte_ff   <= buf_byte_in;
      buf_last_ff   <= buf_last_in;
   end

   // Encode mode never holds bytes.
   assert property (@(posedge clock) disable iff (reset)
      !decode_mode_ff |-> pend_count_ff == upc_pkg::PEND_NONE)
      else $error("held bytes while in encode mode");

   // The final item of a string always leaves nothing held and yields a result.
   assert property (@(posedge clock) disable iff (reset)
      req_take && req_in_last |=> pend_count_ff == upc_pkg::PEND_NONE && rsp_valid)
      else $error("end of string did not flush held bytes");

   // A held hex digit can only follow a held percent sign.
   assert property (@(posedge clock) disable iff (reset)
      pend_count_ff == upc_pkg::PEND_DIGIT |->
         $past(pend_count_ff) == upc_pkg::PEND_PCT ||
         $past(pend_count_ff) == upc_pkg::PEND_DIGIT)
      else $error("hex digit held without a percent sign");

   // The string end flag only rides on the last byte of an item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end && buf_last_ff)
      else $error("string end flag on a byte that is not last");

endmodule
`default_nettype wire

// File: rtl/core/upc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upc_step
// Combinational conversion of one input byte: the result bytes it causes and
// the next held-byte state of the decoder.
// ----------------------------------------------------------------------------
module upc_step (
   input  wire logic             decode_mode,
   input  wire logic [1:0]       pend_count,
   input  wire logic [7:0]       pend_digit,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_last,
   output upc_pkg::step_type     step
);

   logic       c_pct;
   logic       c_hex;
   logic [7:0] c_mapped;

   assign c_pct    = (in_byte == upc_pkg::CHAR_PCT);
   assign c_hex    = upc_pkg::is_hex(in_byte);
   assign c_mapped = (in_byte == upc_pkg::CHAR_PLUS) ? upc_pkg::CHAR_SPACE : in_byte;

   always_comb begin
      step            = '0;
      step.next_count = upc_pkg::PEND_NONE;
      if (!decode_mode) begin
         if (in_byte == upc_pkg::CHAR_SPACE) begin
            step.res_byte[0] = upc_pkg::CHAR_PLUS;
            step.res_count   = 2'd1;
         end else if (upc_pkg::must_escape(in_byte)) begin
            step.res_byte[0] = upc_pkg::CHAR_PCT;
            step.res_byte[1] = upc_pkg::hex_digit(in_byte[7:4]);
            step.res_byte[2] = upc_pkg::hex_digit(in_byte[3:0]);
            step.res_count   = 2'd3;
         end else begin
            step.res_byte[0] = in_byte;
            step.res_count   = 2'd1;
         end
      end else begin
         case (pend_count)
            upc_pkg::PEND_PCT: begin
               if (c_hex) begin
                  step.next_count  = upc_pkg::PEND_DIGIT;
                  step.digit_we    = 1'b1;
                  // At the end of the string both held bytes go out as they are.
                  step.res_byte[0] = upc_pkg::CHAR_PCT;
                  step.res_byte[1] = in_byte;
                  step.res_count   = in_last ? 2'd2 : 2'd0;
               end else if (c_pct) begin
                  step.next_count  = upc_pkg::PEND_PCT;
                  step.res_byte[0] = upc_pkg::CHAR_PCT;
                  step.res_byte[1] = upc_pkg::CHAR_PCT;
                  step.res_count   = in_last ? 2'd2 : 2'd1;
               end else begin
                  step.res_byte[0] = upc_pkg::CHAR_PCT;
                  step.res_byte[1] = c_mapped;
                  step.res_count   = 2'd2;
               end
            end
            upc_pkg::PEND_DIGIT: begin
               if (c_hex) begin
                  step.res_byte[0] = {upc_pkg::hex_value(pend_digit),
                                      upc_pkg::hex_value(in_byte)};
                  step.res_count   = 2'd1;
               end else begin
                  step.res_byte[0] = upc_pkg::CHAR_PCT;
                  step.res_byte[1] = pend_digit;
                  if (c_pct) begin
                     step.next_count  = upc_pkg::PEND_PCT;
                     step.res_byte[2] = upc_pkg::CHAR_PCT;
                     step.res_count   = in_last ? 2'd3 : 2'd2;
                  end else begin
                     step.res_byte[2] = c_mapped;
                     step.res_count   = 2'd3;
                  end
               end
            end
            default: begin
               if (c_pct) begin
                  step.next_count  = upc_pkg::PEND_PCT;
                  step.res_byte[0] = upc_pkg::CHAR_PCT;
                  step.res_count   = in_last ? 2'd1 : 2'd0;
               end else begin
                  step.res_byte[0] = c_mapped;
                  step.res_count   = 2'd1;
               end
            end
         endcase
         if (in_last) begin
            step.next_count = upc_pkg::PEND_NONE;
         end
      end
   end

endmodule
`default_nettype wire

// File: dv/url_percent_codec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec_checker
// Watches the item, result and register channels of the URL percent codec,
// predicts the bytes every accepted item must produce and compares them in
// order with the result items the block returns.
// ----------------------------------------------------------------------------
module url_percent_codec_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_run_end,
   input  wire logic        rsp_string_end,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic [31:0] prdata,
   input  wire logic        pready,
   output int               error_count,
   output int               backlog,
   output int               checked_count
);

   localparam int REG_DECODE_MODE = 0;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       string_end;
   } out_byte_type;

   out_byte_type expected_q[$];
   logic       decode_on;
   logic [1:0] held_count;
   logic [7:0] held_digit;
   logic [7:0] step_bytes [3];
   int         step_n;

   function automatic logic hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      if (c <= "9") begin
         v = c - "0";
      end else if (c <= "F") begin
         v = c - "A" + 8'd10;
      end else begin
         v = c - "a" + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] upper_hex(input logic [3:0] n);
      if (n < 4'd10) begin
         return "0" + {4'h0, n};
      end
      return "A" + ({4'h0, n} - 8'd10);
   endfunction

   // Controls, DEL and up, plus the reserved, delimiter and unwise characters.
   function automatic logic escape_needed(input logic [7:0] c);
      if (c <= 8'h1F || c >= 8'h7F) begin
         return 1'b1;
      end
      case (c)
         ";", "/", "?", ":", "@", "&", "=", "+", "$", ",",
         "<", ">", "#", "%", "\"",
         "{", "}", "|", "\\", "^", "[", "]", 8'h60: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic emit(input logic [7:0] b);
      if (step_n < 3) begin
         step_bytes[step_n] = b;
         step_n++;
      end
   endtask

   // Scan a byte with nothing held; a percent starts a new escape.
   task automatic scan_fresh(input logic [7:0] c);
      if (c == upc_pkg::CHAR_PCT) begin
         held_count = upc_pkg::PEND_PCT;
      end else begin
         held_count = upc_pkg::PEND_NONE;
         emit(c == upc_pkg::CHAR_PLUS ? upc_pkg::CHAR_SPACE : c);
      end
   endtask

   task automatic convert_item(input logic [7:0] c, input logic last);
      step_n = 0;
      if (decode_on) begin
         case (held_count)
            upc_pkg::PEND_PCT: begin
               if (hex_char(c)) begin
                  held_digit = c;
                  held_count = upc_pkg::PEND_DIGIT;
               end else begin
                  held_count = upc_pkg::PEND_NONE;
                  emit(upc_pkg::CHAR_PCT);
                  scan_fresh(c);
               end
            end
            upc_pkg::PEND_DIGIT: begin
               held_count = upc_pkg::PEND_NONE;
               if (hex_char(c)) begin
                  emit({nibble_of(held_digit), nibble_of(c)});
               end else begin
                  // A failed escape gives back its held bytes, which are not rescanned.
                  emit(upc_pkg::CHAR_PCT);
                  emit(held_digit);
                  scan_fresh(c);
               end
            end
            default: scan_fresh(c);
         endcase
         if (last) begin
            if (held_count == upc_pkg::PEND_PCT || held_count == upc_pkg::PEND_DIGIT) begin
               emit(upc_pkg::CHAR_PCT);
            end
            if (held_count == upc_pkg::PEND_DIGIT) begin
               emit(held_digit);
            end
            held_count = upc_pkg::PEND_NONE;
         end
      end else begin
         held_count = upc_pkg::PEND_NONE;
         if (c == upc_pkg::CHAR_SPACE) begin
            emit(upc_pkg::CHAR_PLUS);
         end else if (escape_needed(c)) begin
            emit(upc_pkg::CHAR_PCT);
            emit(upper_hex(c[7:4]));
            emit(upper_hex(c[3:0]));
         end else begin
            emit(c);
         end
      end
      for (int i = 0; i < step_n; i++) begin
         expected_q.push_back('{step_bytes[i], i == step_n - 1, last && (i == step_n - 1)});
      end
   endtask

   task automatic report(input string field, input logic [7:0] want_v, input logic [7:0] got_v);
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
   endtask

   always @(posedge clock) begin
      out_byte_type want;
      if (reset) begin
         decode_on     = 1'b0;
         held_count    = upc_pkg::PEND_NONE;
         held_digit    = 8'h00;
         error_count   = 0;
         checked_count = 0;
         expected_q.delete();
      end else begin
         if (psel && penable && pready && (paddr >> 2) == REG_DECODE_MODE) begin
            if (pwrite) begin
               decode_on  = pwdata[0];
               held_count = upc_pkg::PEND_NONE;
            end else if (prdata !== {31'b0, decode_on}) begin
               error_count++;
               $display("%0t: mode readback mismatch, expected %h, got %h",
                        $time, {31'b0, decode_on}, prdata);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               error_count++;
               $display("%0t: result item %h arrived with none expected, expected nothing, got %h",
                        $time, rsp_out_byte, rsp_out_byte);
            end else begin
               want = expected_q.pop_front();
               checked_count++;
               if (rsp_out_byte !== want.data) begin
                  report("out_byte", want.data, rsp_out_byte);
               end
               if (rsp_run_end !== want.run_end) begin
                  report("run_end", {7'b0, want.run_end}, {7'b0, rsp_run_end});
               end
               if (rsp_string_end !== want.string_end) begin
                  report("string_end", {7'b0, want.string_end}, {7'b0, rsp_string_end});
               end
            end
         end
         if (req_valid && req_ready) begin
            convert_item(req_in_byte, req_in_last);
         end
      end
      backlog = expected_q.size();
   end

endmodule

// File: dv/url_percent_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec_test
// Sends byte strings through the URL percent codec in encode and decode mode,
// with random stalls on both channels, and gives the verdict of the checker.
// ----------------------------------------------------------------------------
module url_percent_codec_test;

   localparam logic [2:0] MODE_ADDR        = 3'd0;
   localparam logic [2:0] SPARE_ADDR       = 3'd4;   // first address past the registers
   localparam logic       MODE_ENCODE      = 1'b0;
   localparam logic       MODE_DECODE      = 1'b1;
   localparam int         SETTLE_CYCLES    = 8;
   localparam int         LONG_HOLD_CYCLES = 120;
   localparam int         ITEMS_PER_PHASE  = 40;
   localparam int         NUM_PHASES       = 6;
   localparam int         LIMIT_CYCLES     = 200000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [7:0]  req_in_byte    = 8'h00;
   logic        req_in_last    = 1'b0;
   logic        rsp_ready      = 1'b0;
   logic        psel           = 1'b0;
   logic        penable        = 1'b0;
   logic        pwrite         = 1'b0;
   logic [2:0]  paddr          = 3'd0;
   logic [31:0] pwdata         = 32'h0;
   wire logic        req_ready;
   wire logic        rsp_valid;
   wire logic [7:0]  rsp_out_byte;
   wire logic        rsp_run_end;
   wire logic        rsp_string_end;
   wire logic [31:0] prdata;
   wire logic        pready;

   logic        rsp_hold_req   = 1'b0;
   logic        calm           = 1'b0;
   logic        cur_mode       = MODE_ENCODE;
   logic [7:0]  str_q[$];
   int          items_sent     = 0;
   int          encode_items   = 0;
   int          decode_items   = 0;
   int          mode_writes    = 0;
   int          cycle_count    = 0;
   int          error_count;
   int          backlog;
   int          checked_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   url_percent_codec u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   url_percent_codec_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .error_count    (error_count),
      .backlog        (backlog),
      .checked_count  (checked_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d result items outstanding.",
                  cycle_count, backlog);
         $display("url_percent_codec test failed");
         $finish;
      end
   end

   // Result side: random stall bursts, ready stretches, and one long hold on request.
   initial begin
      @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   task automatic wait_idle();
      while (backlog != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic [2:0] addr, input logic [31:0] data,
                             input logic is_write);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = is_write;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Only bit 0 of the mode register counts, so the upper bits carry noise.
   task automatic set_mode(input logic m);
      logic [31:0] noise;
      noise = $urandom();
      wait_idle();
      csr_access(MODE_ADDR, {noise[31:1], m}, 1'b1);
      csr_access(MODE_ADDR, 32'h0, 1'b0);
      cur_mode = m;
      mode_writes++;
   endtask

   task automatic send_item(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_in_byte = b;
      req_in_last = last;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      req_valid = 1'b0;
      items_sent++;
      if (cur_mode == MODE_DECODE) begin
         decode_items++;
      end else begin
         encode_items++;
      end
   endtask

   function automatic logic [7:0] rand_hex_digit();
      logic [7:0] v;
      v = 8'($urandom_range(0, 15));
      if (v < 8'd10) begin
         return "0" + v;
      end
      return ($urandom_range(0, 1) ? "A" : "a") + (v - 8'd10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(8'h00, 8'h2F));
         1:       return 8'($urandom_range(8'h3A, 8'h40));
         2:       return 8'($urandom_range(8'h47, 8'h60));
         default: return 8'($urandom_range(8'h67, 8'hFF));
      endcase
   endfunction

   initial begin
      int  n;
      int  phase_items;
      bit  paused;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_access(MODE_ADDR, 32'h0, 1'b0);
      // Encode: controls, DEL and up, space, a plain byte and reserved characters.
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h1F, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(upc_pkg::CHAR_SPACE, 1'b0);
      send_item("~", 1'b0);
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      send_item(upc_pkg::CHAR_PLUS, 1'b1);

      set_mode(MODE_DECODE);
      // A good escape, a plus, and an escape broken after its first digit.
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      send_item("4", 1'b0);
      send_item("1", 1'b0);
      send_item(upc_pkg::CHAR_PLUS, 1'b0);
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      send_item("6", 1'b0);
      send_item("z", 1'b0);
      // Percent after percent, then a mixed-case pair; then an escape cut short by the end.
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      send_item("f", 1'b0);
      send_item("F", 1'b0);
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      send_item("a", 1'b1);
      // A write past the register list leaves a held percent alone.
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      wait_idle();
      csr_access(SPARE_ADDR, $urandom(), 1'b1);
      send_item("4", 1'b0);
      send_item("2", 1'b1);
      // A mode write drops it.
      send_item(upc_pkg::CHAR_PCT, 1'b0);
      set_mode(MODE_DECODE);
      send_item("x", 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         phase_items = 0;
         if (p == NUM_PHASES - 1) begin
            calm <= 1'b1;
         end
         set_mode(p % 2 == 0 ? MODE_ENCODE : MODE_DECODE);
         if (p == 2) begin
            rsp_hold_req <= 1'b1;
         end
         while (phase_items < ITEMS_PER_PHASE) begin
            if (p == 3 && !paused && phase_items >= ITEMS_PER_PHASE / 2) begin
               wait_idle();
               paused = 1'b1;
            end
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               if (cur_mode == MODE_DECODE) begin
                  // Well-formed escapes most often; else a plus, a broken or dangling escape, or a raw byte.
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: begin
                        str_q.push_back(upc_pkg::CHAR_PCT);
                        str_q.push_back(rand_hex_digit());
                        str_q.push_back(rand_hex_digit());
                     end
                     4: str_q.push_back(upc_pkg::CHAR_PLUS);
                     5: begin
                        str_q.push_back(upc_pkg::CHAR_PCT);
                        str_q.push_back(rand_non_hex());
                     end
                     6: begin
                        str_q.push_back(upc_pkg::CHAR_PCT);
                        str_q.push_back(rand_hex_digit());
                        str_q.push_back(rand_non_hex());
                     end
                     7: str_q.push_back(upc_pkg::CHAR_PCT);
                     default: str_q.push_back(8'($urandom_range(0, 255)));
                  endcase
               end else begin
                  case ($urandom_range(0, 3))
                     0:       str_q.push_back(upc_pkg::CHAR_SPACE);
                     1:       str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                     default: str_q.push_back(8'($urandom_range(0, 255)));
                  endcase
               end
            end
            for (int i = 0; i < str_q.size(); i++) begin
               send_item(str_q[i], i == str_q.size() - 1);
            end
            phase_items += str_q.size();
            str_q.delete();
         end
      end

      wait_idle();
      repeat (20) @(negedge clock);
      $display("Covered %0d items (%0d encoded, %0d decoded) over %0d mode writes,",
               items_sent, encode_items, decode_items, mode_writes);
      $display("a long result hold and a mid-run drain; %0d result bytes compared, %0d errors.",
               checked_count, error_count);
      if (error_count == 0 && backlog == 0) begin
         $display("url_percent_codec test passed");
      end else begin
         $display("url_percent_codec test failed");
      end
      $finish;
   end

endmodule
